### hdl/sxf_pkg.sv
// ---------------------------------------------------------------------------
// sxf_pkg - shared types and constants for the sprite XOR framebuffer
// Action codes, result kinds, sequencer states and default screen size.
// ---------------------------------------------------------------------------
package sxf_pkg;

  // default screen geometry
  localparam int SXF_COLUMNS = 64;
  localparam int SXF_ROWS    = 32;

  // coordinate work width: origin (8 bits) plus row offset (4 bits) needs 9
  localparam int COORD_W = 9;

  // sprite rows are one byte wide
  localparam int SPRITE_W = 8;

  // request action codes
  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // result kind codes
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,   // sweeping zeros through the frame store
    ST_IDLE,    // waiting for a request
    ST_ROW,     // wrapping the row coordinate
    ST_COL,     // wrapping the column coordinate
    ST_BASE,    // forming row * columns
    ST_PIX,     // test sprite bit, read pixel if set
    ST_WR,      // write toggled pixel back
    ST_RD,      // read one pixel for scan-out
    ST_RDOUT,   // present pixel read result
    ST_EMIT     // present draw collision result
  } sxf_state_t;

endpackage

### hdl/sxf_mod_unit.sv
// ---------------------------------------------------------------------------
// sxf_mod_unit - shared compare/subtract step
// One step of the wrap reduction: tests value >= modulus, gives the difference.
// ---------------------------------------------------------------------------
module sxf_mod_unit (
  input  logic [sxf_pkg::COORD_W-1:0] value,
  input  logic [sxf_pkg::COORD_W-1:0] modulus,
  output logic                        ge,
  output logic [sxf_pkg::COORD_W-1:0] diff
);
  import sxf_pkg::*;

  assign ge   = (value >= modulus);
  assign diff = value - modulus;

endmodule

### hdl/sxf_frame_mem.sv
// ---------------------------------------------------------------------------
// sxf_frame_mem - one-bit-per-pixel frame store
// Single port, one access per cycle, registered read data.
// ---------------------------------------------------------------------------
module sxf_frame_mem #(
  parameter int DEPTH = sxf_pkg::SXF_COLUMNS * sxf_pkg::SXF_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic          wdata,
  input  logic          re,
  output logic          rdata
);
  import sxf_pkg::*;

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hdl/sprite_xor_framebuffer.sv
// ---------------------------------------------------------------------------
// sprite_xor_framebuffer - monochrome framebuffer with sprite XOR drawing
// Draw row: wrap row and column by repeated subtract, form row * columns, then test
//   each of the eight sprite bits, toggling each set pixel; the last row emits a result.
// Read: same wrap steps and base, then one pixel read and its result. One request at a
//   time, busy for its whole run, set by the wrap steps and the one-port pixel store.
// Reset and clear: a sweep over all COLS*ROWS pixels zeroes the store, busy held.
// Results are strobed on done for one cycle; the receiver cannot stall.
// ---------------------------------------------------------------------------
module sprite_xor_framebuffer #(
  parameter int SCREEN_COLUMNS = sxf_pkg::SXF_COLUMNS,
  parameter int SCREEN_ROWS    = sxf_pkg::SXF_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  // request side
  input  logic       start,
  output logic       busy,
  input  logic [1:0] action,
  input  logic [7:0] x_origin,
  input  logic [7:0] y_origin,
  input  logic [3:0] row_offset,
  input  logic [7:0] row_bits,
  input  logic       first_row,
  input  logic       last_row,
  // result side
  output logic       done,
  output logic       result_kind,
  output logic       collision,
  output logic       pixel_value
);
  import sxf_pkg::*;

  localparam int PIXELS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW     = $clog2(PIXELS);
  localparam int CW     = $clog2(SCREEN_COLUMNS);
  localparam int RW     = $clog2(SCREEN_ROWS);

  localparam logic [AW-1:0]      PIX_LAST = AW'(PIXELS - 1);
  localparam logic [AW-1:0]      COLS_A   = AW'(SCREEN_COLUMNS);
  localparam logic [CW-1:0]      COL_LAST = CW'(SCREEN_COLUMNS - 1);
  localparam logic [COORD_W-1:0] COLS_M   = COORD_W'(SCREEN_COLUMNS);
  localparam logic [COORD_W-1:0] ROWS_M   = COORD_W'(SCREEN_ROWS);

  // sequencer
  sxf_state_t state, state_next;

  // latched request
  logic [1:0]          act;
  logic [7:0]          xo;
  logic [SPRITE_W-1:0] bits;
  logic                last_q;

  // working registers
  logic [COORD_W-1:0]  red;       // value under wrap reduction
  logic [RW-1:0]       row_q;     // wrapped row
  logic [CW-1:0]       col;       // wrapped column of current pixel
  logic [AW-1:0]       base;      // row * columns
  logic [2:0]          j;         // sprite bit index, 0 = leftmost
  logic                coll;      // collision seen since first row
  logic [AW-1:0]       clr_addr;  // clearing sweep pointer

  // shared unit
  logic [COORD_W-1:0]  mod_in;
  logic                mod_ge;
  logic [COORD_W-1:0]  mod_diff;

  // store port
  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  logic                mem_wdata;
  logic                mem_re;
  logic                mem_rdata;

  logic                cur_bit;
  logic                j_last;
  logic [AW-1:0]       pix_addr;

  assign cur_bit  = bits[~j];             // bit 7 first
  assign j_last   = (j == 3'd7);
  assign pix_addr = base + {{(AW-CW){1'b0}}, col};

  sxf_mod_unit u_mod (
    .value   (red),
    .modulus (mod_in),
    .ge      (mod_ge),
    .diff    (mod_diff)
  );

  sxf_frame_mem #(
    .DEPTH (PIXELS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .re    (mem_re),
    .rdata (mem_rdata)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == PIX_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (action)
            ACT_DRAW:  state_next = ST_ROW;
            ACT_READ:  state_next = ST_ROW;
            ACT_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;   // unused code: dropped
          endcase
        end
      end
      ST_ROW: begin
        if (!mod_ge) state_next = ST_COL;
      end
      ST_COL: begin
        if (!mod_ge) state_next = ST_BASE;
      end
      ST_BASE: begin
        state_next = (act == ACT_READ) ? ST_RD : ST_PIX;
      end
      ST_PIX: begin
        if (cur_bit) begin
          state_next = ST_WR;
        end else if (j_last) begin
          state_next = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_WR: begin
        if (j_last) begin
          state_next = last_q ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_PIX;
        end
      end
      ST_RD:    state_next = ST_RDOUT;
      ST_RDOUT: state_next = ST_IDLE;
      ST_EMIT:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    busy        = 1'b1;
    done        = 1'b0;
    result_kind = KIND_DRAW;
    collision   = 1'b0;
    pixel_value = 1'b0;
    mem_addr    = pix_addr;
    mem_we      = 1'b0;
    mem_wdata   = 1'b0;
    mem_re      = 1'b0;
    mod_in      = COLS_M;
    case (state)
      ST_CLEAR: begin
        mem_addr  = clr_addr;
        mem_we    = 1'b1;
        mem_wdata = 1'b0;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_ROW: begin
        mod_in = ROWS_M;
      end
      ST_PIX: begin
        mem_re = cur_bit;
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_wdata = ~mem_rdata;   // XOR with a set sprite bit
      end
      ST_RD: begin
        mem_re = 1'b1;
      end
      ST_RDOUT: begin
        done        = 1'b1;
        result_kind = KIND_READ;
        pixel_value = mem_rdata;
      end
      ST_EMIT: begin
        done        = 1'b1;
        result_kind = KIND_DRAW;
        collision   = coll;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      coll     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          if (start) begin
            act    <= action;
            xo     <= x_origin;
            bits   <= row_bits;
            last_q <= last_row;
            // reads wrap the bare origin; draws add the row offset
            if (action == ACT_READ) begin
              red <= {1'b0, y_origin};
            end else begin
              red <= {1'b0, y_origin} + {{(COORD_W-4){1'b0}}, row_offset};
            end
            if (action == ACT_DRAW && first_row) coll <= 1'b0;
            if (action == ACT_CLEAR) clr_addr <= '0;
          end
        end
        ST_ROW: begin
          if (mod_ge) begin
            red <= mod_diff;
          end else begin
            row_q <= red[RW-1:0];
            red   <= {1'b0, xo};
          end
        end
        ST_COL: begin
          if (mod_ge) begin
            red <= mod_diff;
          end else begin
            col <= red[CW-1:0];
            j   <= 3'd0;
          end
        end
        ST_BASE: begin
          base <= {{(AW-RW){1'b0}}, row_q} * COLS_A;
        end
        ST_PIX: begin
          if (!cur_bit) begin
            col <= (col == COL_LAST) ? '0 : col + 1'b1;
            j   <= j + 1'b1;
          end
        end
        ST_WR: begin
          if (mem_rdata) coll <= 1'b1;   // lit pixel turned off
          col <= (col == COL_LAST) ? '0 : col + 1'b1;
          j   <= j + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/sxf_checker.sv
// ---------------------------------------------------------------------------
// sxf_checker - port-level checks for the sprite XOR framebuffer
// Watches request and result ports; attached to the top level by bind.
// ---------------------------------------------------------------------------
module sxf_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] action,
  input logic       done,
  input logic       result_kind,
  input logic       collision,
  input logic       pixel_value
);
  import sxf_pkg::*;

  // a result is a one-cycle strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // no request can be taken while a result is shown
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done while not busy");

  // an accepted draw keeps the block busy at least for the wrap step
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_DRAW) |=> busy)
    else $error("draw request did not raise busy");

  // unused fields of a result are zero
  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result_kind == KIND_READ) |-> !collision)
    else $error("read result carries collision");

  a_draw_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result_kind == KIND_DRAW) |-> !pixel_value)
    else $error("draw result carries pixel value");

endmodule

bind sprite_xor_framebuffer sxf_checker u_sxf_checker (.*);
